>>> hdl/vlc_pkg.sv
package vlc_pkg;

  localparam int GROUP_BITS = 7;
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 32;

  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_VALUE = 1'b1;

  typedef struct packed {
    logic              func;
    logic              is_signed;
    logic [WORD_W-1:0] value_in;
    logic [BYTE_W-1:0] in_byte;
  } req_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] out_byte;
    logic [WORD_W-1:0] out_value;
    logic              last;
    logic              error;
  } rsp_t;

  // Decoder result for the beat being accepted.
  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] value;
    logic              error;
  } dec_res_t;

endpackage

>>> hdl/varint_codec_sign_lsb.sv
// channel  valid      stall      payload        direction
// req      req_valid  req_stall  req (req_t)    in
// rsp      rsp_valid  rsp_stall  rsp (rsp_t)    out
//
// In a decode beat, a non-final byte only updates the accumulator. An encode
// beat emits 1 to ceil(VALUE_BITS/7) bytes: the work register shifts out one
// 7-bit group per cycle while rsp is not stalled and holds req_stall until
// the last group leaves. Reset clears the decode state and both valids.
// A stalled rsp holds its beat; req still loads into an empty work register.
module varint_codec_sign_lsb #(
  parameter int VALUE_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  vlc_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output vlc_pkg::rsp_t   rsp
);

  localparam int WIDE = (VALUE_BITS > vlc_pkg::WORD_W) ? VALUE_BITS : vlc_pkg::WORD_W;
  localparam int GB   = vlc_pkg::GROUP_BITS;

  // work register: one pending item
  logic                        a_valid;
  logic                        a_kind;
  logic [VALUE_BITS-1:0]       a_bits;
  logic [vlc_pkg::WORD_W-1:0]  a_value;
  logic                        a_err;

  logic                  accept;
  logic                  dec_step;
  vlc_pkg::dec_res_t     dec_res;

  logic [WIDE-1:0]       v_wide;
  logic [VALUE_BITS-1:0] v;
  logic [VALUE_BITS-1:0] neg_v;
  logic [VALUE_BITS-1:0] enc_bits;
  logic                  enc_err;

  logic                  rest_nz;
  logic                  a_final;
  logic                  rsp_free;
  logic                  emit;
  logic                  a_free;
  vlc_pkg::rsp_t         beat;

  always_comb begin
    v_wide  = WIDE'(req.value_in);
    v       = v_wide[VALUE_BITS-1:0];
    neg_v   = VALUE_BITS'(0) - v;
    enc_err = 1'b0;
    if (!req.is_signed) begin
      enc_bits = v;
    end else if (v[VALUE_BITS-1]) begin
      enc_bits = {neg_v[VALUE_BITS-2:0], 1'b1};
      // the minimum negates to itself
      enc_err  = (v[VALUE_BITS-2:0] == '0);
    end else begin
      enc_bits = {v[VALUE_BITS-2:0], 1'b0};
    end
  end

  always_comb begin
    rest_nz   = |a_bits[VALUE_BITS-1:GB];
    a_final   = (a_kind == vlc_pkg::KIND_VALUE) || !rest_nz;
    rsp_free  = !rsp_valid || !rsp_stall;
    emit      = a_valid && rsp_free;
    a_free    = !a_valid || (emit && a_final);
    req_stall = !a_free;
    accept    = req_valid && a_free;
    dec_step  = accept && (req.func == vlc_pkg::FUNC_DECODE);

    beat.kind  = a_kind;
    beat.error = a_err;
    if (a_kind == vlc_pkg::KIND_BYTE) begin
      beat.out_byte  = {rest_nz, a_bits[GB-1:0]};
      beat.out_value = '0;
      beat.last      = !rest_nz;
    end else begin
      beat.out_byte  = '0;
      beat.out_value = a_value;
      beat.last      = 1'b1;
    end
  end

  vlc_dec #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dec (
    .clk       (clk),
    .rst       (rst),
    .step      (dec_step),
    .byte_in   (req.in_byte),
    .is_signed (req.is_signed),
    .res       (dec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      if (req.func == vlc_pkg::FUNC_ENCODE) begin
        a_valid <= 1'b1;
        a_kind  <= vlc_pkg::KIND_BYTE;
        a_bits  <= enc_bits;
        a_err   <= enc_err;
      end else begin
        a_valid <= dec_res.done;
        a_kind  <= vlc_pkg::KIND_VALUE;
        a_value <= dec_res.value;
        a_err   <= dec_res.error;
      end
    end else if (emit) begin
      if (a_final) begin
        a_valid <= 1'b0;
      end else begin
        // advance to the next group
        a_bits <= a_bits >> GB;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
      rsp       <= beat;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

>>> hdl/vlc_dec.sv
module vlc_dec #(
  parameter int VALUE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [vlc_pkg::BYTE_W-1:0]  byte_in,
  input  logic                        is_signed,
  output vlc_pkg::dec_res_t           res
);

  localparam int SHW   = VALUE_BITS + vlc_pkg::GROUP_BITS;
  localparam int POS_W = $clog2(SHW);
  localparam int WIDE  = (VALUE_BITS > vlc_pkg::WORD_W) ? VALUE_BITS : vlc_pkg::WORD_W;

  logic [VALUE_BITS-1:0] accumulator;
  logic [VALUE_BITS-1:0] accumulator_next;
  logic [POS_W-1:0]      bit_position;
  logic [POS_W-1:0]      bit_position_next;
  logic                  lost_bits;
  logic                  lost_bits_next;

  logic [vlc_pkg::GROUP_BITS-1:0] grp;
  logic [SHW-1:0]                 shifted;
  logic                           in_range;
  logic [VALUE_BITS-1:0]          mag;
  logic [VALUE_BITS-1:0]          val;
  logic [WIDE-1:0]                val_wide;

  always_comb begin
    grp      = byte_in[vlc_pkg::GROUP_BITS-1:0];
    shifted  = SHW'(grp) << bit_position;
    in_range = bit_position < POS_W'(VALUE_BITS);

    accumulator_next  = accumulator;
    bit_position_next = bit_position;
    lost_bits_next    = lost_bits;
    if (in_range) begin
      // bits pushed above the top of the word are dropped
      if (shifted[SHW-1:VALUE_BITS] != '0) begin
        lost_bits_next = 1'b1;
      end
      accumulator_next  = accumulator | shifted[VALUE_BITS-1:0];
      bit_position_next = bit_position + POS_W'(vlc_pkg::GROUP_BITS);
    end else if (grp != '0) begin
      lost_bits_next = 1'b1;
    end

    mag = accumulator_next >> 1;
    if (is_signed) begin
      val = accumulator_next[0] ? (VALUE_BITS'(0) - mag) : mag;
    end else begin
      val = accumulator_next;
    end
    val_wide = WIDE'(val);

    res.done  = step && !byte_in[vlc_pkg::BYTE_W-1];
    res.value = val_wide[vlc_pkg::WORD_W-1:0];
    res.error = lost_bits_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator  <= '0;
      bit_position <= '0;
      lost_bits    <= 1'b0;
    end else if (step) begin
      if (res.done) begin
        accumulator  <= '0;
        bit_position <= '0;
        lost_bits    <= 1'b0;
      end else begin
        accumulator  <= accumulator_next;
        bit_position <= bit_position_next;
        lost_bits    <= lost_bits_next;
      end
    end
  end

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VBITS       = vlc_pkg::WORD_W;
  localparam int ITEM_TARGET = 410;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [vlc_pkg::WORD_W-1:0] word_t;
  typedef logic [vlc_pkg::BYTE_W-1:0] octet_q_t[$];
  typedef vlc_pkg::rsp_t rsp_q_t[$];

  typedef struct packed {
    vlc_pkg::req_t beat;
    logic          pin;
    vlc_pkg::rsp_t want;
  } row_t;

  localparam vlc_pkg::rsp_t NO_RSP = '0;
  localparam word_t CORNER_VALS [6] = '{
    32'h0000_0000, 32'h0000_007F, 32'h0000_0080,
    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF
  };

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  vlc_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  vlc_pkg::rsp_t rsp;

  // decoder state mirror
  word_t dec_acc  = '0;
  int    dec_pos  = 0;
  logic  dec_lost = 1'b0;

  vlc_pkg::rsp_t want_q[$];
  row_t plan[$];
  logic calm          = 1'b0;
  int   items_sent    = 0;
  int   n_encode      = 0;
  int   n_bytes_seen  = 0;
  int   n_values_seen = 0;
  int   fails         = 0;
  int   cycles        = 0;

  varint_codec_sign_lsb #(
    .VALUE_BITS(VBITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic vlc_pkg::rsp_t byte_beat(logic [vlc_pkg::BYTE_W-1:0] b, logic lst,
                                              logic er);
    vlc_pkg::rsp_t r;
    r          = '0;
    r.kind     = vlc_pkg::KIND_BYTE;
    r.out_byte = b;
    r.last     = lst;
    r.error    = er;
    return r;
  endfunction

  function automatic vlc_pkg::rsp_t value_beat(word_t v, logic er);
    vlc_pkg::rsp_t r;
    r           = '0;
    r.kind      = vlc_pkg::KIND_VALUE;
    r.out_value = v;
    r.last      = 1'b1;
    r.error     = er;
    return r;
  endfunction

  function automatic vlc_pkg::req_t mk_req(logic fn, logic sg, word_t v,
                                           logic [vlc_pkg::BYTE_W-1:0] b);
    vlc_pkg::req_t r;
    r.func      = fn;
    r.is_signed = sg;
    r.value_in  = v;
    r.in_byte   = b;
    return r;
  endfunction

  // Zigzag-style sign move to bit 0, then split into 7-bit groups, low first.
  function automatic void varint_bytes(input logic sg, input word_t v,
                                       output octet_q_t seq, output logic err);
    word_t bits;
    word_t mag;
    seq = {};
    err = 1'b0;
    if (sg && v[vlc_pkg::WORD_W-1]) begin
      mag  = '0 - v;
      bits = {mag[vlc_pkg::WORD_W-2:0], 1'b1};
      err  = (v == {1'b1, {(vlc_pkg::WORD_W-1){1'b0}}});
    end else if (sg) begin
      bits = {v[vlc_pkg::WORD_W-2:0], 1'b0};
    end else begin
      bits = v;
    end
    do begin
      seq.push_back((bits >> vlc_pkg::GROUP_BITS) != 0 ? {1'b1, bits[6:0]} : bits[7:0]);
      bits = bits >> vlc_pkg::GROUP_BITS;
    end while (bits != 0);
  endfunction

  function automatic void codec_predict(input vlc_pkg::req_t beat, output rsp_q_t outs);
    octet_q_t    seq;
    logic        err;
    logic [6:0]  grp;
    logic [63:0] wide;
    word_t       val;
    int          room;
    outs = {};
    if (beat.func == vlc_pkg::FUNC_ENCODE) begin
      varint_bytes(beat.is_signed, beat.value_in, seq, err);
      foreach (seq[i]) outs.push_back(byte_beat(seq[i], i == seq.size() - 1, err));
    end else begin
      grp = beat.in_byte[6:0];
      if (dec_pos < VBITS) begin
        room = VBITS - dec_pos;
        if (room < vlc_pkg::GROUP_BITS && (grp >> room) != 0) dec_lost = 1'b1;
        wide    = {32'd0, dec_acc} | ({57'd0, grp} << dec_pos);
        dec_acc = wide[vlc_pkg::WORD_W-1:0];
        dec_pos = dec_pos + vlc_pkg::GROUP_BITS;
      end else if (grp != 0) begin
        dec_lost = 1'b1;
      end
      if (!beat.in_byte[7]) begin
        val = dec_acc;
        if (beat.is_signed) val = val[0] ? ('0 - (val >> 1)) : (val >> 1);
        outs.push_back(value_beat(val, dec_lost));
        dec_acc  = '0;
        dec_pos  = 0;
        dec_lost = 1'b0;
      end
    end
  endfunction

  function automatic word_t pick_value();
    word_t v;
    case ($urandom_range(5))
      0: v = $urandom_range(127);
      1: v = $urandom >> $urandom_range(31);
      2: v = $urandom;
      3: v = '0 - $urandom_range(1, 300);
      4: v = CORNER_VALS[3'($urandom_range(5))];
      default: v = $urandom | 32'h8000_0000;
    endcase
    return v;
  endfunction

  // Hold valid and payload until the beat is taken, then record what it owes.
  task automatic send_beat(input vlc_pkg::req_t beat, input logic pin,
                           input vlc_pkg::rsp_t want);
    rsp_q_t outs;
    while (!calm && $urandom_range(99) < 12) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= beat;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    codec_predict(beat, outs);
    if (pin) want_q.push_back(want);
    else foreach (outs[i]) want_q.push_back(outs[i]);
    items_sent++;
    if (beat.func == vlc_pkg::FUNC_ENCODE) n_encode++;
  endtask

  task automatic flag_field(input string name, input word_t w, input word_t g);
    $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, w, g);
    fails++;
  endtask

  task automatic check_beat(input vlc_pkg::rsp_t got);
    vlc_pkg::rsp_t want;
    if (want_q.size() == 0) begin
      $display("%0t: unexpected result beat: expected none, got %p", $time, got);
      fails++;
    end else begin
      want = want_q.pop_front();
      if (got.kind !== want.kind)
        flag_field("kind", word_t'(want.kind), word_t'(got.kind));
      if (got.out_byte !== want.out_byte)
        flag_field("out_byte", word_t'(want.out_byte), word_t'(got.out_byte));
      if (got.out_value !== want.out_value)
        flag_field("out_value", want.out_value, got.out_value);
      if (got.last !== want.last)
        flag_field("last", word_t'(want.last), word_t'(got.last));
      if (got.error !== want.error)
        flag_field("error", word_t'(want.error), word_t'(got.error));
      if (want.kind == vlc_pkg::KIND_BYTE) n_bytes_seen++;
      else n_values_seen++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) check_beat(rsp);
      rsp_stall <= !calm && ($urandom_range(99) < 12);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, want_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    octet_q_t seq;
    logic     sg;
    logic     err;
    int       n;

    // straight after reset, extremes, sign corner cases
    plan.push_back(row_t'{mk_req(vlc_pkg::FUNC_DECODE, 1'b0, 32'h0, 8'h00), 1'b1,
                          value_beat(32'h0, 1'b0)});
    plan.push_back(row_t'{mk_req(vlc_pkg::FUNC_ENCODE, 1'b0, 32'h0, 8'hFF), 1'b1,
                          byte_beat(8'h00, 1'b1, 1'b0)});
    plan.push_back(row_t'{mk_req(vlc_pkg::FUNC_ENCODE, 1'b0, 32'h7F, 8'h00), 1'b1,
                          byte_beat(8'h7F, 1'b1, 1'b0)});
    plan.push_back(row_t'{mk_req(vlc_pkg::FUNC_ENCODE, 1'b0, 32'h80, 8'h00), 1'b0,
                          NO_RSP});
    plan.push_back(row_t'{mk_req(vlc_pkg::FUNC_ENCODE, 1'b0, 32'hFFFF_FFFF, 8'h00), 1'b0,
                          NO_RSP});
    plan.push_back(row_t'{mk_req(vlc_pkg::FUNC_ENCODE, 1'b1, 32'h8000_0000, 8'h00), 1'b1,
                          byte_beat(8'h01, 1'b1, 1'b1)});
    plan.push_back(row_t'{mk_req(vlc_pkg::FUNC_ENCODE, 1'b1, 32'h7FFF_FFFF, 8'h00), 1'b0,
                          NO_RSP});
    plan.push_back(row_t'{mk_req(vlc_pkg::FUNC_ENCODE, 1'b1, 32'hFFFF_FFFF, 8'h00), 1'b1,
                          byte_beat(8'h03, 1'b1, 1'b0)});
    plan.push_back(row_t'{mk_req(vlc_pkg::FUNC_DECODE, 1'b1, 32'h0, 8'h03), 1'b1,
                          value_beat(32'hFFFF_FFFF, 1'b0)});
    // negative zero decodes to zero
    plan.push_back(row_t'{mk_req(vlc_pkg::FUNC_DECODE, 1'b1, 32'h0, 8'h01), 1'b1,
                          value_beat(32'h0, 1'b0)});
    // top group overflows past bit 31
    repeat (4) plan.push_back(row_t'{mk_req(vlc_pkg::FUNC_DECODE, 1'b0, 32'h0, 8'hFF),
                                     1'b0, NO_RSP});
    plan.push_back(row_t'{mk_req(vlc_pkg::FUNC_DECODE, 1'b0, 32'h0, 8'h1F), 1'b1,
                          value_beat(32'hFFFF_FFFF, 1'b1)});
    // position saturates; a nonzero group beyond it is lost
    repeat (5) plan.push_back(row_t'{mk_req(vlc_pkg::FUNC_DECODE, 1'b0, 32'h0, 8'h80),
                                     1'b0, NO_RSP});
    plan.push_back(row_t'{mk_req(vlc_pkg::FUNC_DECODE, 1'b0, 32'h0, 8'h01), 1'b1,
                          value_beat(32'h0, 1'b1)});
    // encode in the middle of a partial decode
    plan.push_back(row_t'{mk_req(vlc_pkg::FUNC_DECODE, 1'b1, 32'h0, 8'h85), 1'b0,
                          NO_RSP});
    plan.push_back(row_t'{mk_req(vlc_pkg::FUNC_ENCODE, 1'b0, 32'd300, 8'h00), 1'b0,
                          NO_RSP});
    plan.push_back(row_t'{mk_req(vlc_pkg::FUNC_DECODE, 1'b0, 32'h0, 8'h01), 1'b0,
                          NO_RSP});

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_beat(plan[i].beat, plan[i].pin, plan[i].want);

    while (items_sent < ITEM_TARGET) begin
      calm = (items_sent >= 160 && items_sent < 250);
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          send_beat(mk_req(vlc_pkg::FUNC_ENCODE, 1'($urandom_range(1)), pick_value(),
                           8'($urandom_range(255))), 1'b0, NO_RSP);
        end
        4, 5, 6, 7: begin
          sg = 1'($urandom_range(1));
          varint_bytes(sg, pick_value(), seq, err);
          // pad with zero groups now and then
          if ($urandom_range(5) == 0) begin
            seq[seq.size() - 1] |= 8'h80;
            repeat ($urandom_range(3)) seq.push_back(8'h80);
            seq.push_back(8'h00);
          end
          foreach (seq[i]) begin
            if ($urandom_range(19) == 0)
              send_beat(mk_req(vlc_pkg::FUNC_ENCODE, 1'($urandom_range(1)), pick_value(),
                               8'($urandom_range(255))), 1'b0, NO_RSP);
            send_beat(mk_req(vlc_pkg::FUNC_DECODE,
                             (i == seq.size() - 1) ? sg : 1'($urandom_range(1)),
                             $urandom, seq[i]), 1'b0, NO_RSP);
          end
        end
        8: begin
          n = $urandom_range(1, 4);
          repeat (n) send_beat(mk_req(vlc_pkg::FUNC_DECODE, 1'($urandom_range(1)), $urandom,
                                      8'($urandom_range(255))), 1'b0, NO_RSP);
        end
        default: begin
          // overlong run with random groups
          n = $urandom_range(4, 7);
          repeat (n) send_beat(mk_req(vlc_pkg::FUNC_DECODE, 1'($urandom_range(1)), $urandom,
                                      {1'b1, 7'($urandom_range(127))}), 1'b0, NO_RSP);
          send_beat(mk_req(vlc_pkg::FUNC_DECODE, 1'($urandom_range(1)), $urandom,
                           8'($urandom_range(127))), 1'b0, NO_RSP);
        end
      endcase
    end
    req_valid <= 1'b0;
    calm = 1'b0;

    while (want_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d request beats (%0d encodes, rest decode bytes).",
             items_sent, n_encode);
    $display("Checked %0d encoded bytes and %0d decoded values.",
             n_bytes_seen, n_values_seen);
    if (fails == 0 && want_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
